// ----- src/lppr_pkg.sv -----
// ----------------------------------------------------------------------------
// lppr_pkg
// Types, register map, reset values and the per-channel predictor function
// for the lossless pixel predictor residual core.
// ----------------------------------------------------------------------------
package lppr_pkg;

    localparam int MAX_WIDTH_DEF = 2048;

    localparam int PRED_MODE_W    = 4;
    localparam int IMAGE_WIDTH_W  = 12;
    localparam int IMAGE_HEIGHT_W = 16;
    localparam int PADDR_W        = 4;
    localparam int PDATA_W        = 32;

    localparam logic [PRED_MODE_W-1:0]    PRED_MODE_RST    = 4'd4;
    localparam logic [IMAGE_WIDTH_W-1:0]  IMAGE_WIDTH_RST  = 12'd512;
    localparam logic [IMAGE_HEIGHT_W-1:0] IMAGE_HEIGHT_RST = 16'd512;

    localparam logic [1:0] REG_PRED_MODE    = 2'd0;
    localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd1;
    localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd2;

    localparam logic [PRED_MODE_W-1:0] MODE_LEFT      = 4'd1;
    localparam logic [PRED_MODE_W-1:0] MODE_UP        = 4'd2;
    localparam logic [PRED_MODE_W-1:0] MODE_UPLEFT    = 4'd3;
    localparam logic [PRED_MODE_W-1:0] MODE_PLANE     = 4'd4;
    localparam logic [PRED_MODE_W-1:0] MODE_LEFT_GRAD = 4'd5;
    localparam logic [PRED_MODE_W-1:0] MODE_UP_GRAD   = 4'd6;
    localparam logic [PRED_MODE_W-1:0] MODE_AVERAGE   = 4'd7;
    localparam logic [PRED_MODE_W-1:0] MODE_MED       = 4'd8;

    typedef struct packed {
        logic [7:0] pix_blue;
        logic [7:0] pix_green;
        logic [7:0] pix_red;
    } pix_t;

    typedef struct packed {
        logic       frame_end;
        logic [7:0] res_blue;
        logic [7:0] res_green;
        logic [7:0] res_red;
    } res_t;

    function automatic logic [7:0] residual(
        input logic [PRED_MODE_W-1:0] mode,
        input logic [7:0]             x,
        input logic [7:0]             a,
        input logic [7:0]             b,
        input logic [7:0]             c
    );
        logic signed [10:0] sa;
        logic signed [10:0] sb;
        logic signed [10:0] sc;
        logic signed [10:0] hi;
        logic signed [10:0] lo;
        logic signed [10:0] d;
        logic signed [10:0] p;
        sa = signed'({3'b000, a});
        sb = signed'({3'b000, b});
        sc = signed'({3'b000, c});
        hi = (sa > sb) ? sa : sb;
        lo = (sa > sb) ? sb : sa;
        d  = '0;
        p  = '0;
        unique case (mode)
            MODE_LEFT:      p = sa;
            MODE_UP:        p = sb;
            MODE_UPLEFT:    p = sc;
            MODE_PLANE:     p = sa + sb - sc;
            MODE_LEFT_GRAD:
            begin
                d = sb - sc;
                d = d + signed'({10'd0, d[10]});
                p = sa + (d >>> 1);
            end
            MODE_UP_GRAD:
            begin
                d = sa - sc;
                d = d + signed'({10'd0, d[10]});
                p = sb + (d >>> 1);
            end
            MODE_AVERAGE:
            begin
                d = sa + sb;
                p = d >>> 1;
            end
            MODE_MED:
            begin
                if (sc >= hi)
                begin
                    p = lo;
                end
                else if (sc <= lo)
                begin
                    p = hi;
                end
                else
                begin
                    p = sa + sb - sc;
                end
            end
            default:        p = '0;
        endcase
        return x - p[7:0];
    endfunction

endpackage

// ----- src/lossless_pixel_predictor_residual_core.sv -----
// ----------------------------------------------------------------------------
// lossless_pixel_predictor_residual_core
// Per-pixel RGB prediction residual with line store, neighbour registers,
// raster counters and an APB register port.
// ----------------------------------------------------------------------------
// One pixel per clock unless the output stalls; results are registered. The
// line store has one write port and a registered read port; the upper
// neighbour of the next pixel is fetched while the current one is written,
// with a bypass where both fall on the same column, so no pixel waits on the
// memory. The input is taken whenever the result register is empty or being
// drained. Registers: 0x0 pred_mode, 0x4 image_width, 0x8 image_height.
module lossless_pixel_predictor_residual_core #(
    parameter int MAX_WIDTH = lppr_pkg::MAX_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  lppr_pkg::pix_t               in_data,
    output logic                         out_valid,
    input  logic                         out_ready,
    output lppr_pkg::res_t               out_data,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [lppr_pkg::PADDR_W-1:0] paddr,
    input  logic [lppr_pkg::PDATA_W-1:0] pwdata,
    output logic [lppr_pkg::PDATA_W-1:0] prdata,
    output logic                         pready
);

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int CMPW = (CW + 1 > 13) ? CW + 1 : 13;

    logic [lppr_pkg::PRED_MODE_W-1:0]    mode_reg;
    logic [lppr_pkg::IMAGE_WIDTH_W-1:0]  width_reg;
    logic [lppr_pkg::IMAGE_HEIGHT_W-1:0] height_reg;

    lppr_pkg::pix_t row_mem [MAX_WIDTH];
    lppr_pkg::pix_t upper_q_reg;
    lppr_pkg::pix_t byp_data_reg;
    logic           byp_reg;

    lppr_pkg::pix_t left_reg;
    lppr_pkg::pix_t upleft_reg;
    logic [CW-1:0]  col_reg;
    logic [CW-1:0]  col_next;
    logic [lppr_pkg::IMAGE_HEIGHT_W-1:0] row_reg;
    logic [lppr_pkg::IMAGE_HEIGHT_W-1:0] row_next;

    lppr_pkg::res_t res_reg;
    lppr_pkg::res_t res_next;
    logic           out_valid_reg;

    logic           acc;
    logic           cfg_wr;
    lppr_pkg::pix_t a_pix;
    lppr_pkg::pix_t b_pix;
    lppr_pkg::pix_t c_pix;
    logic [CMPW-1:0] w_ext;
    logic [CMPW-1:0] w_m1;
    logic [lppr_pkg::IMAGE_HEIGHT_W-1:0] h_m1;
    logic           row_end;
    logic           last;

    assign pready    = 1'b1;
    assign cfg_wr    = psel && penable && pwrite;
    assign in_ready  = !out_valid_reg || out_ready;
    assign acc       = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = res_reg;

    always_comb
    begin
        unique case (paddr[3:2])
            lppr_pkg::REG_PRED_MODE:
                prdata = lppr_pkg::PDATA_W'(mode_reg);
            lppr_pkg::REG_IMAGE_WIDTH:
                prdata = lppr_pkg::PDATA_W'(width_reg);
            lppr_pkg::REG_IMAGE_HEIGHT:
                prdata = lppr_pkg::PDATA_W'(height_reg);
            default:
                prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= lppr_pkg::PRED_MODE_RST;
            width_reg  <= lppr_pkg::IMAGE_WIDTH_RST;
            height_reg <= lppr_pkg::IMAGE_HEIGHT_RST;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                lppr_pkg::REG_PRED_MODE:
                    mode_reg <= pwdata[lppr_pkg::PRED_MODE_W-1:0];
                lppr_pkg::REG_IMAGE_WIDTH:
                    width_reg <= pwdata[lppr_pkg::IMAGE_WIDTH_W-1:0];
                lppr_pkg::REG_IMAGE_HEIGHT:
                    height_reg <= pwdata[lppr_pkg::IMAGE_HEIGHT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        w_ext = CMPW'(width_reg);
        if (width_reg == '0)
        begin
            w_m1 = '0;
        end
        else if (w_ext > CMPW'(MAX_WIDTH))
        begin
            w_m1 = CMPW'(MAX_WIDTH - 1);
        end
        else
        begin
            w_m1 = w_ext - CMPW'(1);
        end
        h_m1    = (height_reg == '0) ? '0 : height_reg - 1'b1;
        row_end = CMPW'(col_reg) >= w_m1;
        last    = row_end && (row_reg >= h_m1);

        if (row_end)
        begin
            col_next = '0;
            row_next = last ? '0 : row_reg + 1'b1;
        end
        else
        begin
            col_next = col_reg + CW'(1);
            row_next = row_reg;
        end

        a_pix = (col_reg == '0) ? '0 : left_reg;
        b_pix = (row_reg == '0) ? '0 : (byp_reg ? byp_data_reg : upper_q_reg);
        c_pix = (col_reg == '0 || row_reg == '0) ? '0 : upleft_reg;

        res_next.res_red   = lppr_pkg::residual(mode_reg, in_data.pix_red,
                                                a_pix.pix_red, b_pix.pix_red,
                                                c_pix.pix_red);
        res_next.res_green = lppr_pkg::residual(mode_reg, in_data.pix_green,
                                                a_pix.pix_green, b_pix.pix_green,
                                                c_pix.pix_green);
        res_next.res_blue  = lppr_pkg::residual(mode_reg, in_data.pix_blue,
                                                a_pix.pix_blue, b_pix.pix_blue,
                                                c_pix.pix_blue);
        res_next.frame_end = last;
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            row_mem[col_reg] <= in_data;
            upper_q_reg      <= row_mem[col_next];
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            byp_data_reg <= in_data;
            left_reg     <= in_data;
            upleft_reg   <= b_pix;
            res_reg      <= res_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            byp_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (acc)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
                byp_reg <= (col_next == col_reg);
            end
            if (acc)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // hold the column counter inside the line store
    assert property (@(posedge clk) disable iff (!rst_n)
        CMPW'(col_reg) <= CMPW'(MAX_WIDTH - 1))
        else $error("column counter beyond line store depth");

    // wrap both counters after the last pixel of an image
    assert property (@(posedge clk) disable iff (!rst_n)
        (acc && last) |=> (col_reg == '0 && row_reg == '0 && res_reg.frame_end))
        else $error("counters not wrapped after frame end");

    // advance to the next row only at row end
    assert property (@(posedge clk) disable iff (!rst_n)
        (acc && !row_end) |=> (row_reg == $past(row_reg) && col_reg != '0))
        else $error("row advanced before row end");

endmodule

// ----- bench/lossless_pixel_predictor_residual_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lossless_pixel_predictor_residual_core_tb
// Self-checking bench for the RGB predictor residual core. Pixels stream in
// over a valid/ready channel with random gaps and back-pressure. An in-bench
// predictor tracks neighbours, line store and raster counters to form the
// expected residual and frame-end flag for every transaction. Geometry and
// predictor mode change over APB between drained phases, covering all modes,
// unused modes, clamped and mid-image geometry changes.
// ----------------------------------------------------------------------------
module lossless_pixel_predictor_residual_core_tb;

    localparam int          MAXW       = lppr_pkg::MAX_WIDTH_DEF;
    localparam int          STALL_MAX  = 4000;
    localparam int          RAND_ITEMS = 1330;
    localparam logic [3:0]  MODE_NONE  = 4'd0;
    localparam logic [3:0]  MODE_SPARE = 4'd15;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           in_valid = 1'b0;
    logic                           in_ready;
    lppr_pkg::pix_t                 in_data = '0;
    logic                           out_valid;
    logic                           out_ready = 1'b0;
    lppr_pkg::res_t                 out_data;
    logic                           psel = 1'b0;
    logic                           penable = 1'b0;
    logic                           pwrite = 1'b0;
    logic [lppr_pkg::PADDR_W-1:0]   paddr = '0;
    logic [lppr_pkg::PDATA_W-1:0]   pwdata = '0;
    logic [lppr_pkg::PDATA_W-1:0]   prdata;
    logic                           pready;

    lppr_pkg::pix_t       pixel_queue[$];
    lppr_pkg::res_t       residual_queue[$];

    logic [23:0]          line_mem [0:MAXW-1];
    logic [23:0]          left_q;
    logic [23:0]          upleft_q;
    int unsigned          col_cnt;
    int unsigned          row_cnt;
    int unsigned          filled;
    logic [3:0]           mode_cfg;
    logic [11:0]          width_cfg;
    logic [15:0]          height_cfg;

    logic                 steady = 1'b0;
    int unsigned          stall_cycles = 0;
    int unsigned          fail_count = 0;
    int unsigned          pixels_done = 0;
    int unsigned          frames_seen = 0;
    logic [15:0]          modes_seen = '0;

    lossless_pixel_predictor_residual_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic logic [7:0] chan_residual(
        input logic [3:0] m,
        input logic [7:0] x,
        input logic [7:0] a,
        input logic [7:0] b,
        input logic [7:0] c
    );
        int pa;
        int pb;
        int pc;
        int hi;
        int lo;
        int p;
        pa = a;
        pb = b;
        pc = c;
        hi = (pa > pb) ? pa : pb;
        lo = (pa > pb) ? pb : pa;
        case (m)
            lppr_pkg::MODE_LEFT:      p = pa;
            lppr_pkg::MODE_UP:        p = pb;
            lppr_pkg::MODE_UPLEFT:    p = pc;
            lppr_pkg::MODE_PLANE:     p = pa + pb - pc;
            lppr_pkg::MODE_LEFT_GRAD: p = pa + (pb - pc) / 2;
            lppr_pkg::MODE_UP_GRAD:   p = pb + (pa - pc) / 2;
            lppr_pkg::MODE_AVERAGE:   p = (pa + pb) / 2;
            lppr_pkg::MODE_MED:
                p = (pc >= hi) ? lo : (pc <= lo) ? hi : pa + pb - pc;
            default:                  p = 0;
        endcase
        return 8'(int'(x) - p);
    endfunction

    task automatic compute_residual(input lppr_pkg::pix_t px, output lppr_pkg::res_t r);
        int unsigned w;
        int unsigned h;
        int unsigned col;
        logic [23:0] x;
        logic [23:0] a;
        logic [23:0] b;
        logic [23:0] c;
        logic        row_end;
        logic        last;
        w = (width_cfg == 0) ? 1 : (width_cfg > MAXW) ? MAXW : width_cfg;
        h = (height_cfg == 0) ? 1 : height_cfg;
        col = col_cnt % MAXW;
        x = px;
        a = (col == 0) ? '0 : left_q;
        b = (row_cnt == 0) ? '0 : line_mem[col];
        c = (col == 0 || row_cnt == 0) ? '0 : upleft_q;
        r.res_red   = chan_residual(mode_cfg, x[7:0], a[7:0], b[7:0], c[7:0]);
        r.res_green = chan_residual(mode_cfg, x[15:8], a[15:8], b[15:8], c[15:8]);
        r.res_blue  = chan_residual(mode_cfg, x[23:16], a[23:16], b[23:16], c[23:16]);
        upleft_q = b;
        left_q = x;
        line_mem[col] = x;
        if (col + 1 > filled)
        begin
            filled = col + 1;
        end
        row_end = (col_cnt >= w - 1);
        last = row_end && (row_cnt >= h - 1);
        if (row_end)
        begin
            col_cnt = 0;
            row_cnt = last ? 0 : ((row_cnt + 1) & 32'hFFFF);
        end
        else
        begin
            col_cnt = col_cnt + 1;
        end
        r.frame_end = last;
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        lppr_pkg::res_t predicted;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                compute_residual(in_data, predicted);
                residual_queue.push_back(predicted);
            end
            if (!in_valid || in_ready)
            begin
                if (pixel_queue.size() != 0 && (steady || $urandom_range(0, 99) >= 25))
                begin
                    in_valid <= 1'b1;
                    in_data <= pixel_queue.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        lppr_pkg::res_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                pixels_done++;
                if (out_data.frame_end)
                begin
                    frames_seen++;
                end
                if (residual_queue.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                    begin
                        $display("ERROR: unexpected result %h at %0t", out_data, $realtime);
                    end
                end
                else
                begin
                    want = residual_queue.pop_front();
                    if (out_data.res_red !== want.res_red
                        || out_data.res_green !== want.res_green
                        || out_data.res_blue !== want.res_blue
                        || out_data.frame_end !== want.frame_end)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                        begin
                            $display({"ERROR: result %0d expected r=%h g=%h b=%h end=%b,",
                                      " got r=%h g=%h b=%h end=%b"},
                                     pixels_done, want.res_red, want.res_green, want.res_blue,
                                     want.frame_end, out_data.res_red, out_data.res_green,
                                     out_data.res_blue, out_data.frame_end);
                        end
                    end
                end
            end
            out_ready <= steady || ($urandom_range(0, 99) >= 25);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready)
            || (pixel_queue.size() == 0 && !in_valid && residual_queue.size() == 0))
        begin
            stall_cycles <= 0;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial
    begin
        wait (stall_cycles >= STALL_MAX);
        $display("ERROR: no progress for %0d cycles", STALL_MAX);
        $display("*** FAILED ***");
        $finish;
    end

    task automatic wait_drained();
        @(negedge clk);
        while (pixel_queue.size() != 0 || in_valid || residual_queue.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (3) @(posedge clk);
    endtask

    task automatic apb_write(input logic [1:0] idx, input logic [31:0] field,
                             input logic [31:0] mask);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= ($urandom & ~mask) | (field & mask);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // geometry may only widen mid-image as far as the line store has been filled
    task automatic apply_geometry(input logic [3:0] m, input logic [11:0] w,
                                  input logic [15:0] h);
        int unsigned eff;
        wait_drained();
        eff = (w == 0) ? 1 : (w > MAXW) ? MAXW : w;
        if (row_cnt != 0 && eff > filled)
        begin
            w = 12'(filled);
        end
        apb_write(lppr_pkg::REG_PRED_MODE, 32'(m), 32'hF);
        mode_cfg = m;
        apb_write(lppr_pkg::REG_IMAGE_WIDTH, 32'(w), 32'hFFF);
        width_cfg = w;
        apb_write(lppr_pkg::REG_IMAGE_HEIGHT, 32'(h), 32'hFFFF);
        height_cfg = h;
        modes_seen[m] = 1'b1;
    endtask

    function automatic logic [7:0] pick_channel();
        int unsigned sel;
        sel = $urandom_range(0, 7);
        return (sel == 0) ? 8'h00 : (sel == 1) ? 8'hFF : 8'($urandom);
    endfunction

    task automatic send_pixel(input logic [23:0] v);
        pixel_queue.push_back(lppr_pkg::pix_t'(v));
    endtask

    initial
    begin
        int unsigned random_items;
        int unsigned phase;
        int unsigned n;
        int unsigned sel;
        logic [3:0]  m;
        logic [11:0] w;
        logic [15:0] h;
        random_items = 0;
        phase = 0;
        left_q = '0;
        upleft_q = '0;
        col_cnt = 0;
        row_cnt = 0;
        filled = 0;
        mode_cfg = lppr_pkg::PRED_MODE_RST;
        width_cfg = lppr_pkg::IMAGE_WIDTH_RST;
        height_cfg = lppr_pkg::IMAGE_HEIGHT_RST;
        modes_seen[lppr_pkg::PRED_MODE_RST] = 1'b1;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_pixel(24'h000000);
        send_pixel(24'hFFFFFF);
        send_pixel(24'h00FF00);
        send_pixel(24'hFF00FF);

        apply_geometry(lppr_pkg::MODE_MED, 12'd3, 16'd2);
        send_pixel(24'h000000);
        send_pixel(24'hFFFFFF);
        send_pixel(24'h80FF00);
        send_pixel(24'hFF0080);
        send_pixel(24'h00FF7F);
        send_pixel(24'h7F0001);

        apply_geometry(lppr_pkg::MODE_LEFT_GRAD, 12'd0, 16'd0);
        send_pixel(24'hFF00FF);
        send_pixel(24'h01FE80);
        send_pixel(24'h000000);

        apply_geometry(lppr_pkg::MODE_PLANE, 12'd2, 16'd3);
        send_pixel(24'hFFFFFF);
        send_pixel(24'h000000);
        send_pixel(24'h00FFFF);
        send_pixel(24'hFF0000);
        send_pixel(24'h123456);
        send_pixel(24'hFEDCBA);

        apply_geometry(MODE_NONE, 12'd2, 16'd2);
        send_pixel(24'hA5A5A5);
        send_pixel(24'h5A5A5A);

        apply_geometry(MODE_SPARE, 12'd2, 16'd2);
        send_pixel(24'hFFFFFF);
        send_pixel(24'h010203);

        while (random_items < RAND_ITEMS)
        begin
            sel = $urandom_range(0, 19);
            m = (sel < 2)
                ? ((sel == 0) ? MODE_NONE
                              : 4'($urandom_range(lppr_pkg::MODE_MED + 1, MODE_SPARE)))
                : 4'($urandom_range(lppr_pkg::MODE_LEFT, lppr_pkg::MODE_MED));
            sel = $urandom_range(0, 19);
            case (sel)
                0:       w = 12'd0;
                1:       w = 12'($urandom_range(MAXW + 1, 4095));
                2:       w = 12'(MAXW);
                3:       w = 12'($urandom_range(100, 600));
                default: w = 12'($urandom_range(1, 24));
            endcase
            n = (sel >= 1 && sel <= 3) ? $urandom_range(20, 50) : $urandom_range(20, 120);
            sel = $urandom_range(0, 19);
            case (sel)
                0:       h = 16'd0;
                1:       h = 16'hFFFF;
                2:       h = 16'($urandom_range(1, 65535));
                default: h = 16'($urandom_range(1, 6));
            endcase
            apply_geometry(m, w, h);
            steady = (phase == 4);
            if (steady)
            begin
                n = 150;
            end
            repeat (n)
            begin
                send_pixel({pick_channel(), pick_channel(), pick_channel()});
            end
            random_items += n;
            phase++;
            wait_drained();
            steady = 1'b0;
        end

        wait_drained();
        repeat (8) @(posedge clk);
        $display("Checked %0d pixel transactions over %0d phases, %0d frame ends seen,",
                 pixels_done, phase + 6, frames_seen);
        $display("predictor settings used: %b (bit per mode value)", modes_seen);
        if (fail_count == 0 && residual_queue.size() == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("%0d mismatches, %0d results outstanding", fail_count,
                     residual_queue.size());
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ----- files.f -----
src/lppr_pkg.sv
src/lossless_pixel_predictor_residual_core.sv
bench/lossless_pixel_predictor_residual_core_tb.sv
